FILE: hw/rtl/gwtb_pkg.sv
// Shared constants for the gradient-weighted threshold binarizer.
// Holds field widths, default size limits and config register codes.
// No dependencies.
package gwtb_pkg;

  // default image size limits
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // field and state widths
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 7;
  localparam int WSUM_W     = 28;
  localparam int GSUM_W     = 20;
  localparam int PROD_W     = PIX_W + GSUM_W;
  localparam int LCNT_W     = 13;
  localparam int ROW_BITS_W = 64;
  localparam int COLIX_W    = $clog2(ROW_BITS_W);
  localparam int ROW_NUM_W  = 6;

  // config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

endpackage

FILE: hw/rtl/gwtb_store.sv
// Pixel store: one write port, two registered read ports.
// Depends on gwtb_pkg for the pixel width.
module gwtb_store #(
  parameter int DEPTH = gwtb_pkg::MAX_WIDTH_DEF * gwtb_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(gwtb_pkg::MAX_WIDTH_DEF * gwtb_pkg::MAX_HEIGHT_DEF)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [gwtb_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [gwtb_pkg::PIX_W-1:0] rdata_a,
  output logic [gwtb_pkg::PIX_W-1:0] rdata_b
);

  logic [gwtb_pkg::PIX_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/gwtb_mul.sv
// Shared registered multiplier: pixel times gradient or gradient sum.
// Depends on gwtb_pkg for operand widths.
module gwtb_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gwtb_pkg::PIX_W-1:0]  a,
  input  logic [gwtb_pkg::GSUM_W-1:0] b,
  output logic [gwtb_pkg::PROD_W-1:0] p
);

  // one product per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      p <= gwtb_pkg::PROD_W'(a) * gwtb_pkg::PROD_W'(b);
    end
  end

endmodule

FILE: hw/rtl/gradient_weighted_threshold_binarize.sv
// Gradient-weighted mean threshold binarizer, top level.
// Pixels load at one per cycle while in_stall is low; after the last pixel a gradient
// pass steps through states G0, G1, G2 and G3 per pixel, then GEND, and each row steps
// through T0, T1 and T2 per pixel, then waits in TROW for the output register. The pace
// is set by the single shared multiplier and the two read ports of the pixel store.
// Reset clears control, sums and counters and sets both sizes to 64; store is not cleared.
module gradient_weighted_threshold_binarize #(
  parameter int MAX_WIDTH  = gwtb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gwtb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gwtb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gwtb_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gwtb_pkg::PIX_W-1:0]     grey_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gwtb_pkg::ROW_BITS_W-1:0] row_bits,
  output logic [gwtb_pkg::ROW_NUM_W-1:0] row_number,
  output logic                           last_row
);

  localparam int SW       = gwtb_pkg::SIZE_W;
  localparam int PW       = gwtb_pkg::PIX_W;
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW       = AW + SW;
  localparam int SIZE_MAX = 2 ** SW - 1;
  localparam int WCAP     = (MAX_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_WIDTH;
  localparam int HCAP     = (MAX_HEIGHT > SIZE_MAX) ? SIZE_MAX : MAX_HEIGHT;
  localparam logic [SW-1:0] W_CAP   = SW'(WCAP);
  localparam logic [SW-1:0] H_CAP   = SW'(HCAP);
  localparam logic [SW-1:0] SIZE_RST = SW'(64);

  // sequencer states
  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_G0   = 4'd1;
  localparam logic [3:0] S_G1   = 4'd2;
  localparam logic [3:0] S_G2   = 4'd3;
  localparam logic [3:0] S_G3   = 4'd4;
  localparam logic [3:0] S_GEND = 4'd5;
  localparam logic [3:0] S_T0   = 4'd6;
  localparam logic [3:0] S_T1   = 4'd7;
  localparam logic [3:0] S_T2   = 4'd8;
  localparam logic [3:0] S_TROW = 4'd9;

  logic [3:0]                        state;
  logic [SW-1:0]                     image_width;
  logic [SW-1:0]                     image_height;
  logic [gwtb_pkg::LCNT_W-1:0]       load_count;
  logic [gwtb_pkg::WSUM_W-1:0]       weighted_sum;
  logic [gwtb_pkg::GSUM_W-1:0]       gradient_sum;
  logic [SW-1:0]                     row;
  logic [SW-1:0]                     col;
  logic [AW-1:0]                     idx;
  logic [PW-1:0]                     left_px;
  logic [PW-1:0]                     center_px;
  logic [PW-1:0]                     above_px;
  logic [PW-1:0]                     grad;
  logic                              acc_pending;
  logic [gwtb_pkg::ROW_BITS_W-1:0]   bits_work;

  logic [SW-1:0]                     w_eff;
  logic [SW-1:0]                     h_eff;
  logic [2*SW-1:0]                   total;
  logic [gwtb_pkg::LCNT_W-1:0]       load_count_next;
  logic                              load_take;
  logic                              store_we;
  logic [AW-1:0]                     raddr_a;
  logic [AW-1:0]                     raddr_b;
  logic [PW-1:0]                     qa;
  logic [PW-1:0]                     qb;
  logic [XW-1:0]                     idx_x;
  logic [XW-1:0]                     w_x;
  logic                              col_last;
  logic                              row_last;
  logic [PW-1:0]                     right_v;
  logic [PW-1:0]                     below_v;
  logic [PW-1:0]                     grad_v;
  logic [PW-1:0]                     grad_h;
  logic [PW-1:0]                     grad_next;
  logic                              mul_en;
  logic [PW-1:0]                     mul_a;
  logic [gwtb_pkg::GSUM_W-1:0]       mul_b;
  logic [gwtb_pkg::PROD_W-1:0]       prod;
  logic                              out_take;
  logic                              row_load;

  function automatic logic [PW-1:0] abs_diff(input logic [PW-1:0] x, input logic [PW-1:0] y);
    abs_diff = (x >= y) ? (x - y) : (y - x);
  endfunction

  // effective image size, zero treated as one, large values saturated
  always_comb begin
    if (image_width == '0) begin
      w_eff = SW'(1);
    end else if (image_width > W_CAP) begin
      w_eff = W_CAP;
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = SW'(1);
    end else if (image_height > H_CAP) begin
      h_eff = H_CAP;
    end else begin
      h_eff = image_height;
    end
  end

  assign total           = (2*SW)'(w_eff) * (2*SW)'(h_eff);
  assign load_count_next = load_count + gwtb_pkg::LCNT_W'(1);
  assign load_take       = in_valid && !in_stall;
  assign in_stall        = (state != S_LOAD);
  assign store_we        = load_take && (int'(load_count) < DEPTH);
  assign col_last        = (col == w_eff - SW'(1));
  assign row_last        = (row == h_eff - SW'(1));

  // store read addresses: center/above, then right/below
  assign idx_x = XW'(idx);
  assign w_x   = XW'(w_eff);
  always_comb begin
    case (state)
      S_G0: begin
        raddr_a = idx;
        raddr_b = AW'(idx_x - w_x);
      end
      S_G1: begin
        raddr_a = AW'(idx_x + XW'(1));
        raddr_b = AW'(idx_x + w_x);
      end
      default: begin
        raddr_a = idx;
        raddr_b = idx;
      end
    endcase
  end

  gwtb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (AW'(load_count)),
    .wdata   (grey_value),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (qa),
    .rdata_b (qb)
  );

  // gradient: neighbors outside the image read as zero
  assign right_v   = col_last ? '0 : qa;
  assign below_v   = row_last ? '0 : qb;
  assign grad_v    = abs_diff(below_v, above_px);
  assign grad_h    = abs_diff(right_v, left_px);
  assign grad_next = (grad_v > grad_h) ? grad_v : grad_h;

  // shared multiplier: pixel*gradient in the gradient pass, pixel*gradient_sum later
  assign mul_en = (state == S_G3) || (state == S_T1);
  assign mul_a  = (state == S_G3) ? center_px : qa;
  assign mul_b  = (state == S_G3) ? gwtb_pkg::GSUM_W'(grad) : gradient_sum;

  gwtb_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign out_take = out_valid && !out_stall;
  assign row_load = (state == S_TROW) && (!out_valid || !out_stall);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RST;
      image_height <= SIZE_RST;
    end else if (cfg_write) begin
      if (cfg_index == gwtb_pkg::CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_index == gwtb_pkg::CFG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // sequencer, counters and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      load_count   <= '0;
      weighted_sum <= '0;
      gradient_sum <= '0;
      acc_pending  <= 1'b0;
      row          <= '0;
      col          <= '0;
      idx          <= '0;
      left_px      <= '0;
      bits_work    <= '0;
    end else begin
      // product of the previous pixel is added in the cycle after the multiply
      acc_pending <= 1'b0;
      if (acc_pending) begin
        weighted_sum <= weighted_sum + gwtb_pkg::WSUM_W'(prod);
      end
      case (state)
        S_LOAD: begin
          if (load_take) begin
            if ((2*SW)'(load_count_next) >= total) begin
              load_count   <= '0;
              state        <= S_G0;
              row          <= '0;
              col          <= '0;
              idx          <= '0;
              left_px      <= '0;
              weighted_sum <= '0;
              gradient_sum <= '0;
            end else begin
              load_count <= load_count_next;
            end
          end
        end
        S_G0: begin
          state <= S_G1;
        end
        S_G1: begin
          center_px <= qa;
          above_px  <= (row == '0) ? '0 : qb;
          state     <= S_G2;
        end
        S_G2: begin
          grad    <= grad_next;
          left_px <= col_last ? '0 : center_px;
          state   <= S_G3;
        end
        S_G3: begin
          gradient_sum <= gradient_sum + gwtb_pkg::GSUM_W'(grad);
          acc_pending  <= 1'b1;
          idx          <= AW'(idx_x + XW'(1));
          if (col_last) begin
            col <= '0;
            if (row_last) begin
              state <= S_GEND;
            end else begin
              row   <= row + SW'(1);
              state <= S_G0;
            end
          end else begin
            col   <= col + SW'(1);
            state <= S_G0;
          end
        end
        S_GEND: begin
          row       <= '0;
          col       <= '0;
          idx       <= '0;
          bits_work <= '0;
          state     <= S_T0;
        end
        S_T0: begin
          state <= S_T1;
        end
        S_T1: begin
          state <= S_T2;
        end
        S_T2: begin
          if (gwtb_pkg::WSUM_W'(prod) < weighted_sum) begin
            bits_work[col[gwtb_pkg::COLIX_W-1:0]] <= 1'b1;
          end
          idx <= AW'(idx_x + XW'(1));
          if (col_last) begin
            state <= S_TROW;
          end else begin
            col   <= col + SW'(1);
            state <= S_T0;
          end
        end
        S_TROW: begin
          if (row_load) begin
            bits_work <= '0;
            col       <= '0;
            if (row_last) begin
              state <= S_LOAD;
            end else begin
              row   <= row + SW'(1);
              state <= S_T0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (row_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_load) begin
      row_bits   <= bits_work;
      row_number <= gwtb_pkg::ROW_NUM_W'(row);
      last_row   <= row_last;
    end
  end

`ifndef SYNTHESIS
  // a product is folded into the weighted sum once, never in back-to-back cycles
  a_acc_single: assert property (@(posedge clk) disable iff (rst)
    acc_pending |=> !acc_pending)
    else $error("weighted sum accumulate fired twice in a row");

  // column counter stays inside the image during both passes
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (col < w_eff))
    else $error("column counter outside image width");

  // the final row beat carries the bottom row index
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_row) |-> (row_number == gwtb_pkg::ROW_NUM_W'(h_eff - SW'(1))))
    else $error("last row flag on wrong row number");

  // a finished row with a free output register is offered next cycle
  a_row_offer: assert property (@(posedge clk) disable iff (rst)
    (state == S_TROW && !out_valid) |=> out_valid)
    else $error("finished row not offered");
`endif

endmodule

FILE: verif/tb_gradient_weighted_threshold_binarize.sv
// Self-checking testbench for gradient_weighted_threshold_binarize.
// Holds a scoreboard class that predicts each binarized row from the pixels fed in.
// Depends on gwtb_pkg and the block's top level only.
module tb_gradient_weighted_threshold_binarize;

  localparam int STORE_DEPTH   = gwtb_pkg::MAX_WIDTH_DEF * gwtb_pkg::MAX_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 230;

  // pixel patterns used to fill an image
  typedef enum int {
    PAT_RANDOM,
    PAT_FLAT,
    PAT_BLACK_WHITE,
    PAT_DIM,
    PAT_RAMP
  } pattern_t;

  typedef struct packed {
    logic [gwtb_pkg::ROW_BITS_W-1:0] bits;
    logic [gwtb_pkg::ROW_NUM_W-1:0]  num;
    logic                            last;
  } row_t;

  // Scoreboard: mirrors the size registers and the pixel store, and queues the
  // rows each finished image must produce.
  class binarize_scoreboard;
    logic [gwtb_pkg::PIX_W-1:0]  pixels [STORE_DEPTH];
    int unsigned                 loaded;
    logic [gwtb_pkg::SIZE_W-1:0] width_reg;
    logic [gwtb_pkg::SIZE_W-1:0] height_reg;
    row_t                        rows_due [$];
    int                          errors;
    int                          rows_checked;
    int                          images_done;

    function void reset_state();
      loaded     = 0;
      width_reg  = gwtb_pkg::SIZE_W'(gwtb_pkg::MAX_WIDTH_DEF);
      height_reg = gwtb_pkg::SIZE_W'(gwtb_pkg::MAX_HEIGHT_DEF);
      rows_due.delete();
    endfunction

    function void note_size(logic [gwtb_pkg::CFG_IDX_W-1:0] idx,
                            logic [gwtb_pkg::SIZE_W-1:0] val);
      if (idx == gwtb_pkg::CFG_IMAGE_WIDTH) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
    endfunction

    // zero counts as one, anything past the limit saturates
    function int unsigned clamp_dim(logic [gwtb_pkg::SIZE_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    // pixel with zero outside the image
    function int pix_at(int w, int h, int r, int c);
      if (r < 0 || c < 0 || r >= h || c >= w) return 0;
      return int'(pixels[r * w + c]);
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    // Gradient pass, then one row of threshold bits per image row.
    function void threshold_image(int w, int h);
      longint unsigned wsum, gsum, g, p;
      logic [gwtb_pkg::WSUM_W-1:0] ws;
      logic [gwtb_pkg::GSUM_W-1:0] gs;
      int dv, dh;
      row_t rw;
      wsum = 0;
      gsum = 0;
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          dv = pix_at(w, h, r + 1, c) - pix_at(w, h, r - 1, c);
          dh = pix_at(w, h, r, c + 1) - pix_at(w, h, r, c - 1);
          if (dv < 0) dv = -dv;
          if (dh < 0) dh = -dh;
          g = longint'((dv > dh) ? dv : dh);
          wsum += longint'(pix_at(w, h, r, c)) * g;
          gsum += g;
        end
      end
      ws = wsum[gwtb_pkg::WSUM_W-1:0];
      gs = gsum[gwtb_pkg::GSUM_W-1:0];
      // cross-multiplied compare; a zero gradient sum leaves every bit clear
      for (int r = 0; r < h; r++) begin
        rw.bits = '0;
        for (int c = 0; c < w; c++) begin
          p = longint'(pix_at(w, h, r, c));
          if (p * gs < longint'(ws)) rw.bits[c] = 1'b1;
        end
        rw.num  = gwtb_pkg::ROW_NUM_W'(r);
        rw.last = (r == h - 1);
        rows_due.push_back(rw);
      end
      images_done++;
    endfunction

    // accepted pixel beat: store it and close the image once the count is reached
    function void take_pixel(logic [gwtb_pkg::PIX_W-1:0] v);
      int unsigned w, h;
      w = clamp_dim(width_reg, gwtb_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, gwtb_pkg::MAX_HEIGHT_DEF);
      if (loaded < STORE_DEPTH) pixels[loaded] = v;
      loaded++;
      if (loaded < w * h) return;
      loaded = 0;
      threshold_image(w, h);
    endfunction

    // accepted row beat: compare against the oldest queued row
    function void check_row(logic [gwtb_pkg::ROW_BITS_W-1:0] bits,
                            logic [gwtb_pkg::ROW_NUM_W-1:0] num, logic last);
      row_t exp_row;
      if (rows_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected row, expected none, actual bits %h row %0d last %0b",
                 $time, bits, num, last);
        return;
      end
      exp_row = rows_due.pop_front();
      rows_checked++;
      if (bits !== exp_row.bits) begin
        errors++;
        $display("%0t: row_bits mismatch, expected %h actual %h", $time, exp_row.bits, bits);
      end
      if (num !== exp_row.num) begin
        errors++;
        $display("%0t: row_number mismatch, expected %0d actual %0d", $time, exp_row.num, num);
      end
      if (last !== exp_row.last) begin
        errors++;
        $display("%0t: last_row mismatch, expected %0b actual %0b", $time, exp_row.last, last);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [gwtb_pkg::CFG_IDX_W-1:0]  cfg_index = gwtb_pkg::CFG_IMAGE_WIDTH;
  logic [gwtb_pkg::SIZE_W-1:0]     cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [gwtb_pkg::PIX_W-1:0]      grey_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [gwtb_pkg::ROW_BITS_W-1:0] row_bits;
  logic [gwtb_pkg::ROW_NUM_W-1:0]  row_number;
  logic                            last_row;

  binarize_scoreboard sb = new();
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int          pixels_sent = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  gradient_weighted_threshold_binarize dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .grey_value(grey_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_bits  (row_bits),
    .row_number(row_number),
    .last_row  (last_row)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_gradient_weighted_threshold_binarize NOT OK");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [gwtb_pkg::PIX_W-1:0] image_pixel(pattern_t pat,
      logic [gwtb_pkg::PIX_W-1:0] base, int k);
    case (pat)
      PAT_RANDOM:      return gwtb_pkg::PIX_W'($urandom);
      PAT_FLAT:        return base;
      PAT_BLACK_WHITE: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_DIM:         return gwtb_pkg::PIX_W'($urandom_range(0, 3));
      default:         return base + gwtb_pkg::PIX_W'(k * 3);
    endcase
  endfunction

  // output side: check each accepted row beat, then stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_row(row_bits, row_number, last_row);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!out_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
    end
  end

  // both size registers, back to back
  task automatic set_size(input logic [gwtb_pkg::SIZE_W-1:0] w,
                          input logic [gwtb_pkg::SIZE_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= gwtb_pkg::CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    sb.note_size(gwtb_pkg::CFG_IMAGE_WIDTH, w);
    cfg_index <= gwtb_pkg::CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    sb.note_size(gwtb_pkg::CFG_IMAGE_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // one pixel beat; valid drops after it when a gap follows or drop is set
  task automatic send_pixel(input logic [gwtb_pkg::PIX_W-1:0] v, input bit drop);
    int gap;
    in_valid   <= 1'b1;
    grey_value <= v;
    do @(posedge clk); while (in_stall);
    sb.take_pixel(v);
    pixels_sent++;
    gap = pick_gap(in_calm);
    if (drop || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(input int n, input pattern_t pat,
                          input logic [gwtb_pkg::PIX_W-1:0] base);
    for (int k = 0; k < n; k++) send_pixel(image_pixel(pat, base, k), k == n - 1);
  endtask

  // let every queued row drain, then give the block time to settle
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [gwtb_pkg::SIZE_W-1:0] w_raw, h_raw, w2, h2;
    int unsigned total, t2, k;
    int r, phase, directed_count;
    pattern_t pat;
    logic [gwtb_pkg::PIX_W-1:0] base;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    sb.reset_state();
    @(posedge clk);

    // directed: zero size registers give a 1x1 image, whose gradient sum is zero
    set_size(7'd0, 7'd0);
    send_pixel(8'hFF, 1'b1);
    wait_drained();
    set_size(7'd1, 7'd1);
    send_pixel(8'h00, 1'b1);
    wait_drained();
    // small image with the pixel extremes
    set_size(7'd3, 7'd2);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h01, 1'b1);
    wait_drained();
    // all-black image: flat, zero gradient sum
    set_size(7'd2, 7'd2);
    send_run(4, PAT_FLAT, 8'h00);
    wait_drained();
    // flat nonzero image still has edges against the zero border
    send_run(4, PAT_FLAT, 8'h07);
    wait_drained();
    // size shrunk mid-image: next pixel closes the image at the new size
    set_size(7'd4, 7'd2);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd90, 1'b1);
    wait_drained();
    set_size(7'd2, 7'd1);
    send_pixel(8'd33, 1'b1);
    wait_drained();
    directed_count = pixels_sent;

    // random images
    phase = 0;
    while (pixels_sent - directed_count < RANDOM_PIXELS) begin
      r = $urandom_range(0, 99);
      if (phase == 0) begin
        w_raw = 7'd127;
        h_raw = 7'd1;
      end else if (phase == 1) begin
        w_raw = 7'd1;
        h_raw = 7'd127;
      end else if (r < 70) begin
        w_raw = gwtb_pkg::SIZE_W'($urandom_range(1, 8));
        h_raw = gwtb_pkg::SIZE_W'($urandom_range(1, 8));
      end else if (r < 75) begin
        w_raw = $urandom_range(0, 1) ? 7'd64 : gwtb_pkg::SIZE_W'($urandom_range(65, 127));
        h_raw = gwtb_pkg::SIZE_W'($urandom_range(0, 1));
      end else if (r < 80) begin
        w_raw = gwtb_pkg::SIZE_W'($urandom_range(0, 1));
        h_raw = $urandom_range(0, 1) ? 7'd64 : gwtb_pkg::SIZE_W'($urandom_range(65, 127));
      end else if (r < 88) begin
        w_raw = $urandom_range(0, 1) ? 7'd0 : gwtb_pkg::SIZE_W'($urandom_range(1, 6));
        h_raw = (w_raw == 0) ? gwtb_pkg::SIZE_W'($urandom_range(0, 6)) : 7'd0;
      end else begin
        w_raw = gwtb_pkg::SIZE_W'($urandom_range(9, 20));
        h_raw = gwtb_pkg::SIZE_W'($urandom_range(1, 3));
      end
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      pat  = pattern_t'($urandom_range(0, 4));
      base = gwtb_pkg::PIX_W'($urandom);
      set_size(w_raw, h_raw);
      total = sb.clamp_dim(w_raw, gwtb_pkg::MAX_WIDTH_DEF)
            * sb.clamp_dim(h_raw, gwtb_pkg::MAX_HEIGHT_DEF);

      if (total > 1 && $urandom_range(0, 7) == 0) begin
        // broken image: part of it, then a new size before the rest
        k = $urandom_range(1, total - 1);
        send_run(k, pat, base);
        wait_drained();
        w2 = gwtb_pkg::SIZE_W'($urandom_range(1, 6));
        h2 = gwtb_pkg::SIZE_W'($urandom_range(1, 6));
        set_size(w2, h2);
        t2 = 32'(w2) * 32'(h2);
        send_run((t2 > k) ? t2 - k : 1, pat, base);
      end else if (total > 3 && $urandom_range(0, 5) == 0) begin
        // sender holds off mid-image until the output side is empty
        k = $urandom_range(1, total - 1);
        send_run(k, pat, base);
        wait_drained();
        send_run(total - k, pat, base);
      end else begin
        send_run(total, pat, base);
      end
      wait_drained();
      phase++;
    end

    in_calm  = 1'b0;
    out_calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run fed %0d pixels in %0d images and checked %0d rows",
             pixels_sent, sb.images_done, sb.rows_checked);
    $display("sizes from 1x1 to 64 wide and 64 tall, zero, saturated and mid-image size writes");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_gradient_weighted_threshold_binarize OK");
    end else begin
      $display("tb_gradient_weighted_threshold_binarize NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/gwtb_pkg.sv
hw/rtl/gwtb_store.sv
hw/rtl/gwtb_mul.sv
hw/rtl/gradient_weighted_threshold_binarize.sv
verif/tb_gradient_weighted_threshold_binarize.sv
